// File: src/integer_to_roman_encoder_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to Roman numeral encoder
// Both macros sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH
`define INTEGER_TO_ROMAN_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/itre_pkg.sv
// ----------------------------------------------------------------------------
// itre_pkg
// Widths, character codes and the control store of the Roman numeral encoder.
// ----------------------------------------------------------------------------
package itre_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int QUO_W   = 9;
    localparam int CNT_W   = 3;
    localparam int POS_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int PROD_W  = 2 * VALUE_W;

    localparam logic [VALUE_W-1:0] VALUE_MAX   = 12'd3999;
    // x / 10 == (x * 3277) >> 15 for every 12-bit x.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 12'd3277;
    localparam int                 RECIP_SHIFT = 15;

    localparam logic [SYM_W-1:0] CH_NONE = 8'h00;
    localparam logic [SYM_W-1:0] CH_M    = 8'h4D;
    localparam logic [SYM_W-1:0] CH_D    = 8'h44;
    localparam logic [SYM_W-1:0] CH_C    = 8'h43;
    localparam logic [SYM_W-1:0] CH_L    = 8'h4C;
    localparam logic [SYM_W-1:0] CH_X    = 8'h58;
    localparam logic [SYM_W-1:0] CH_V    = 8'h56;
    localparam logic [SYM_W-1:0] CH_I    = 8'h49;

    localparam logic [POS_W-1:0] POS_THOU  = 2'd3;
    localparam logic [POS_W-1:0] POS_HUND  = 2'd2;
    localparam logic [POS_W-1:0] POS_TENS  = 2'd1;
    localparam logic [POS_W-1:0] POS_UNITS = 2'd0;

    localparam logic [1:0] DIV_LAST = 2'd2;

    typedef logic [ADDR_W-1:0] uaddr_t;

    localparam uaddr_t A_WAIT  = 4'd0;
    localparam uaddr_t A_CHECK = 4'd1;
    localparam uaddr_t A_DIV   = 4'd2;
    localparam uaddr_t A_DISP  = 4'd3;
    localparam uaddr_t A_NINE  = 4'd4;
    localparam uaddr_t A_NINE2 = 4'd5;
    localparam uaddr_t A_FOUR  = 4'd6;
    localparam uaddr_t A_FOUR2 = 4'd7;
    localparam uaddr_t A_FIVE  = 4'd8;
    localparam uaddr_t A_ONES  = 4'd9;
    localparam uaddr_t A_ERR   = 4'd10;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_CHECK,
        OP_DIV,
        OP_DISP,
        OP_EMIT,
        OP_ERR
    } op_t;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } sym_sel_t;

    typedef enum logic [1:0] {
        END_NO,
        END_YES,
        END_CNT
    } end_t;

    typedef struct packed {
        op_t      op;
        sym_sel_t sel;
        end_t     endm;
        uaddr_t   tgt;
    } uword_t;

    typedef struct packed {
        logic [QUO_W-1:0]   quo;
        logic [DIGIT_W-1:0] rem;
    } div10_t;

    // Control store. The jump target is taken when the step's condition holds.
    function automatic uword_t ucode(input uaddr_t addr);
        uword_t w;
        case (addr)
            A_WAIT:  w = '{OP_WAIT,  SEL_ONE,  END_NO,  A_CHECK};
            A_CHECK: w = '{OP_CHECK, SEL_ONE,  END_NO,  A_ERR};
            A_DIV:   w = '{OP_DIV,   SEL_ONE,  END_NO,  A_DIV};
            A_DISP:  w = '{OP_DISP,  SEL_ONE,  END_NO,  A_DISP};
            A_NINE:  w = '{OP_EMIT,  SEL_ONE,  END_NO,  A_NINE2};
            A_NINE2: w = '{OP_EMIT,  SEL_TEN,  END_YES, A_DISP};
            A_FOUR:  w = '{OP_EMIT,  SEL_ONE,  END_NO,  A_FOUR2};
            A_FOUR2: w = '{OP_EMIT,  SEL_FIVE, END_YES, A_DISP};
            A_FIVE:  w = '{OP_EMIT,  SEL_FIVE, END_CNT, A_ONES};
            A_ONES:  w = '{OP_EMIT,  SEL_ONE,  END_CNT, A_ONES};
            A_ERR:   w = '{OP_ERR,   SEL_ONE,  END_NO,  A_WAIT};
            default: w = '{OP_WAIT,  SEL_ONE,  END_NO,  A_CHECK};
        endcase
        return w;
    endfunction

    function automatic logic [SYM_W-1:0] symbol_of(input logic [POS_W-1:0] pos,
                                                   input sym_sel_t sel);
        logic [SYM_W-1:0] ch;
        case (pos)
            POS_HUND:
                case (sel)
                    SEL_ONE:  ch = CH_C;
                    SEL_FIVE: ch = CH_D;
                    default:  ch = CH_M;
                endcase
            POS_TENS:
                case (sel)
                    SEL_ONE:  ch = CH_X;
                    SEL_FIVE: ch = CH_L;
                    default:  ch = CH_C;
                endcase
            POS_UNITS:
                case (sel)
                    SEL_ONE:  ch = CH_I;
                    SEL_FIVE: ch = CH_V;
                    default:  ch = CH_X;
                endcase
            default: ch = CH_M;
        endcase
        return ch;
    endfunction

endpackage

// File: src/integer_to_roman_encoder.sv
// Sequence: an accepted value is range-checked, divided down to its four decimal digits, and
// the positions are then visited from the thousands down, each zero position skipped in turn.
// Zero or a value above 3999 gives a single flag beat instead; a receiver that holds off
// stalls the emit and flag steps.
// Throughput is one value at a time, set by the microcode step counter.
// Reset (rst_n, asynchronous) returns the sequencer to its wait step and empties the output.
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// Microcoded sequencer that converts a binary value into a run of Roman
// numeral characters, one per output beat.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [itre_pkg::VALUE_W-1:0]  value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [itre_pkg::SYM_W-1:0]    symbol,
    output logic                          last,
    output logic                          empty_res,
    output logic                          out_of_range
);

    itre_pkg::uaddr_t                     step_reg, step_next;
    logic [itre_pkg::VALUE_W-1:0]         quo_reg, quo_next;
    logic [3:0][itre_pkg::DIGIT_W-1:0]    dig_reg, dig_next;
    logic [1:0]                           dcnt_reg, dcnt_next;
    logic [itre_pkg::POS_W-1:0]           pos_reg, pos_next;
    logic [itre_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [itre_pkg::SYM_W-1:0]           sym_reg, sym_next;
    logic                                 last_reg, last_next;
    logic                                 empty_reg, empty_next;
    logic                                 oor_reg, oor_next;

    itre_pkg::uword_t                     uw;
    itre_pkg::div10_t                     div_res;
    logic [itre_pkg::DIGIT_W-1:0]         cur_dig;
    logic                                 lower_zero;
    logic                                 slot_free;
    logic                                 fin;

    itre_div10 u_div10 (
        .dividend (quo_reg),
        .res      (div_res)
    );

    assign uw        = itre_pkg::ucode(step_reg);
    assign cur_dig   = dig_reg[pos_reg];
    assign slot_free = !out_valid_reg || out_ready;

    // No character follows once every lower decimal position is zero.
    always_comb
    begin
        case (pos_reg)
            itre_pkg::POS_THOU:
                lower_zero = (dig_reg[2] == '0) && (dig_reg[1] == '0) && (dig_reg[0] == '0);
            itre_pkg::POS_HUND:
                lower_zero = (dig_reg[1] == '0) && (dig_reg[0] == '0);
            itre_pkg::POS_TENS:
                lower_zero = (dig_reg[0] == '0);
            default:
                lower_zero = 1'b1;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        quo_next       = quo_reg;
        dig_next       = dig_reg;
        dcnt_next      = dcnt_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sym_next       = sym_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        oor_next       = oor_reg;
        in_ready       = 1'b0;
        fin            = (uw.endm == itre_pkg::END_YES)
                      || ((uw.endm == itre_pkg::END_CNT) && (cnt_reg == 3'd1));

        case (uw.op)
            itre_pkg::OP_WAIT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    quo_next  = value;
                    dcnt_next = '0;
                    pos_next  = itre_pkg::POS_THOU;
                    step_next = uw.tgt;
                end
            end

            itre_pkg::OP_CHECK:
            begin
                if ((quo_reg == '0) || (quo_reg > itre_pkg::VALUE_MAX))
                    step_next = uw.tgt;
                else
                    step_next = itre_pkg::uaddr_t'(step_reg + 1'b1);
            end

            itre_pkg::OP_DIV:
            begin
                quo_next           = itre_pkg::VALUE_W'(div_res.quo);
                dig_next[dcnt_reg] = div_res.rem;
                dcnt_next          = dcnt_reg + 1'b1;
                if (dcnt_reg == itre_pkg::DIV_LAST)
                begin
                    // What is left after three divisions is the thousands digit.
                    dig_next[itre_pkg::POS_THOU] = div_res.quo[itre_pkg::DIGIT_W-1:0];
                    step_next = itre_pkg::uaddr_t'(step_reg + 1'b1);
                end
                else
                begin
                    step_next = uw.tgt;
                end
            end

            itre_pkg::OP_DISP:
            begin
                if (cur_dig == '0)
                begin
                    if (pos_reg == itre_pkg::POS_UNITS)
                        step_next = itre_pkg::A_WAIT;
                    else
                        pos_next = pos_reg - 1'b1;
                end
                else if (cur_dig == 4'd9)
                begin
                    step_next = itre_pkg::A_NINE;
                end
                else if (cur_dig == 4'd4)
                begin
                    step_next = itre_pkg::A_FOUR;
                end
                else if (cur_dig >= 4'd5)
                begin
                    // The five-symbol counts as one of the characters of the digit.
                    cnt_next  = itre_pkg::CNT_W'(cur_dig - 4'd4);
                    step_next = itre_pkg::A_FIVE;
                end
                else
                begin
                    cnt_next  = itre_pkg::CNT_W'(cur_dig);
                    step_next = itre_pkg::A_ONES;
                end
            end

            itre_pkg::OP_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sym_next       = itre_pkg::symbol_of(pos_reg, uw.sel);
                    last_next      = fin && lower_zero;
                    empty_next     = 1'b0;
                    oor_next       = 1'b0;
                    if (fin)
                    begin
                        if (lower_zero)
                        begin
                            step_next = itre_pkg::A_WAIT;
                        end
                        else
                        begin
                            pos_next  = pos_reg - 1'b1;
                            step_next = itre_pkg::A_DISP;
                        end
                    end
                    else
                    begin
                        if (uw.endm == itre_pkg::END_CNT)
                            cnt_next = cnt_reg - 1'b1;
                        step_next = uw.tgt;
                    end
                end
            end

            itre_pkg::OP_ERR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sym_next       = itre_pkg::CH_NONE;
                    last_next      = 1'b1;
                    empty_next     = (quo_reg == '0);
                    oor_next       = (quo_reg != '0);
                    step_next      = uw.tgt;
                end
            end

            default:
            begin
                step_next = itre_pkg::A_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= itre_pkg::A_WAIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        dig_reg   <= dig_next;
        dcnt_reg  <= dcnt_next;
        pos_reg   <= pos_next;
        cnt_reg   <= cnt_next;
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        empty_reg <= empty_next;
        oor_reg   <= oor_next;
    end

    assign out_valid    = out_valid_reg;
    assign symbol       = sym_reg;
    assign last         = last_reg;
    assign empty_res    = empty_reg;
    assign out_of_range = oor_reg;

endmodule

// File: src/itre_div10.sv
// ----------------------------------------------------------------------------
// itre_div10
// Divides a 12-bit value by ten with a reciprocal multiply and gives the
// quotient and the decimal remainder.
// ----------------------------------------------------------------------------
module itre_div10 (
    input  logic [itre_pkg::VALUE_W-1:0] dividend,
    output itre_pkg::div10_t             res
);

    logic [itre_pkg::PROD_W-1:0]  prod;
    logic [itre_pkg::QUO_W-1:0]   quo;
    logic [itre_pkg::VALUE_W-1:0] times_ten;
    logic [itre_pkg::VALUE_W-1:0] diff;

    assign prod = itre_pkg::PROD_W'(dividend) * itre_pkg::PROD_W'(itre_pkg::RECIP_TEN);
    assign quo  = prod[itre_pkg::RECIP_SHIFT +: itre_pkg::QUO_W];

    // quo * 10 as two shifted copies; the remainder is always below ten.
    assign times_ten = itre_pkg::VALUE_W'({quo, 3'b000})
                     + itre_pkg::VALUE_W'({quo, 1'b0});
    assign diff      = dividend - times_ten;

    assign res.quo = quo;
    assign res.rem = diff[itre_pkg::DIGIT_W-1:0];

endmodule

// File: src/integer_to_roman_encoder_sva.sv
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_sva
// Port-level checks on the encoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "integer_to_roman_encoder_defines.svh"

module integer_to_roman_encoder_sva (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [itre_pkg::VALUE_W-1:0]  value,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [itre_pkg::SYM_W-1:0]    symbol,
    input logic                          last,
    input logic                          empty_res,
    input logic                          out_of_range
);

    logic                        flag_beat;
    logic                        char_beat;
    logic                        legal_char;
    logic                        flag_ok;
    logic                        out_stall;
    logic                        in_stall;
    logic                        in_take;
    logic [itre_pkg::SYM_W+2:0]  out_beat;

    assign flag_beat  = out_valid && (empty_res || out_of_range);
    assign char_beat  = out_valid && !empty_res && !out_of_range;
    assign legal_char = (symbol == itre_pkg::CH_M) || (symbol == itre_pkg::CH_D)
                     || (symbol == itre_pkg::CH_C) || (symbol == itre_pkg::CH_L)
                     || (symbol == itre_pkg::CH_X) || (symbol == itre_pkg::CH_V)
                     || (symbol == itre_pkg::CH_I);
    assign flag_ok    = last && (symbol == itre_pkg::CH_NONE) && !(empty_res && out_of_range);
    assign out_stall  = out_valid && !out_ready;
    assign in_stall   = in_valid && !in_ready;
    assign in_take    = in_valid && in_ready;
    assign out_beat   = {symbol, last, empty_res, out_of_range};

    // A stalled beat keeps its contents.
    `ITRE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_beat), "stalled beat changed")

    // A waiting input beat stays offered with the same value.
    `ITRE_ASSERT_NEXT(a_in_hold, in_stall, in_valid && $stable(value), "input beat changed")

    // A flag beat ends its run, carries no character and has one flag only.
    `ITRE_ASSERT_SAME(a_flag_beat, flag_beat, flag_ok, "malformed flag beat")

    // Every ordinary beat carries a numeral letter.
    `ITRE_ASSERT_SAME(a_char_beat, char_beat, legal_char, "illegal numeral character")

    // A value is worked on alone, so the input closes right after a beat is taken.
    `ITRE_ASSERT_NEXT(a_in_busy, in_take, !in_ready, "input taken while busy")

endmodule

bind integer_to_roman_encoder integer_to_roman_encoder_sva u_sva (.*);
